[hw/rtl/vector3_math_unit_macros.svh]
// assertion macros for the vector3 math unit
// used by the rtl file that carries concurrent checks, no other dependencies
`ifndef VECTOR3_MATH_UNIT_MACROS_SVH
`define VECTOR3_MATH_UNIT_MACROS_SVH

// same-cycle implication
`define VMU_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VMU_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/vmu_pkg.sv]
// shared types for the vector3 math unit: operation codes and stage control
// no dependencies
`timescale 1ns / 1ps

package vmu_pkg;

  typedef enum logic [2:0] {
    K_DOT   = 3'd0,
    K_CROSS = 3'd1,
    K_SQ    = 3'd2,
    K_MAG   = 3'd3,
    K_NORM  = 3'd4,
    K_REFL  = 3'd5
  } kind_t;

  // control that travels with each item down the pipeline
  typedef struct packed {
    logic       vld;
    kind_t      kind;
    logic       flag;
    logic       zero;
    logic [2:0] neg;
  } ctl_t;

endpackage

[hw/rtl/vmu_if.sv]
// valid/ready channel interfaces for the vector3 math unit
// no dependencies
`timescale 1ns / 1ps

interface vmu_in_if #(parameter int DATA_WIDTH = 32) ();
  logic                         valid;
  logic                         ready;
  logic [2:0]                   kind;
  logic signed [DATA_WIDTH-1:0] a_x;
  logic signed [DATA_WIDTH-1:0] a_y;
  logic signed [DATA_WIDTH-1:0] a_z;
  logic signed [DATA_WIDTH-1:0] b_x;
  logic signed [DATA_WIDTH-1:0] b_y;
  logic signed [DATA_WIDTH-1:0] b_z;

  modport source(output valid, kind, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
  modport sink(input valid, kind, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface vmu_out_if #(parameter int DATA_WIDTH = 32) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] r_x;
  logic signed [DATA_WIDTH-1:0] r_y;
  logic signed [DATA_WIDTH-1:0] r_z;
  logic signed [DATA_WIDTH-1:0] r_scalar;
  logic                         saturated;

  modport source(output valid, r_x, r_y, r_z, r_scalar, saturated, input ready);
  modport sink(input valid, r_x, r_y, r_z, r_scalar, saturated, output ready);
endinterface

[hw/rtl/vector3_math_unit.sv]
// top level of the vector3 math unit: vmu_front, vmu_sqrt and vmu_div
// pipelines, selection, output register, skid; needs vmu_pkg, vmu_if, macros
`timescale 1ns / 1ps
`include "vector3_math_unit_macros.svh"

// Fully pipelined three-component vector unit in signed fixed point
// (DATA_WIDTH bits, FRAC_BITS fraction bits). Every operation kind takes
// the same path, so one item can be accepted in every cycle while the
// skid is empty, and results come out in order. The item passes
// 2*DATA_WIDTH + FRAC_BITS + 9 registers, the first of them loaded at
// the input transfer edge: six front stages for the products, sums and
// reflect terms, DATA_WIDTH + 1 stages of the bit-per-stage square root,
// DATA_WIDTH + FRAC_BITS + 1 stages of the bit-per-stage normalize
// divider, and the output register. A result that is not taken parks in
// a one-entry skid; while the skid is full the whole pipeline holds and
// in_ch.ready stays low, and it rises again in the cycle after the
// output transfer that empties the skid.
module vector3_math_unit import vmu_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  vmu_in_if.sink     in_ch,
  vmu_out_if.source  out_ch
);

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;
  localparam int NW  = W + F;
  localparam int TW1 = 7 * W;
  localparam int TW2 = 5 * W + 1;
  localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [NW+1:0] MAXQ = {{(NW+3-W){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [NW+1:0] MINQ = ~MAXQ;

  typedef struct packed {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [W-1:0] z;
    logic signed [W-1:0] sc;
    logic                sat;
  } res_t;

  // clamp a signed quotient, {flag, value}
  function automatic logic [W:0] sat_q(input logic signed [NW+1:0] v);
    if (v > MAXQ) return {1'b1, MAXW};
    if (v < MINQ) return {1'b1, MINW};
    return {1'b0, v[W-1:0]};
  endfunction

  // pipeline moves whenever the skid is free
  logic en;
  logic sk_v_r;
  assign en = !sk_v_r;
  assign in_ch.ready = en;

  // front stages
  logic signed [W-1:0] a_in [3];
  logic signed [W-1:0] b_in [3];
  ctl_t                f_ctl;
  logic [PW-1:0]       f_s;
  logic [W-1:0]        f_am [3];
  logic signed [W-1:0] f_rv [3];
  logic signed [W-1:0] f_rsc;

  assign a_in = '{in_ch.a_x, in_ch.a_y, in_ch.a_z};
  assign b_in = '{in_ch.b_x, in_ch.b_y, in_ch.b_z};

  vmu_front #(.W(W), .F(F)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_ch.valid),
    .kind_i (in_ch.kind),
    .a_i    (a_in),
    .b_i    (b_in),
    .ctl_o  (f_ctl),
    .s_o    (f_s),
    .am_o   (f_am),
    .rv_o   (f_rv),
    .rsc_o  (f_rsc)
  );

  // root of the sum of squares, finished results ride along in the tag
  ctl_t           r_ctl;
  logic [W:0]     r_m;
  logic [TW1-1:0] r_tag;

  vmu_sqrt #(.W(W), .TW(TW1)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (f_ctl),
    .s_i   (f_s),
    .tag_i ({f_am[0], f_am[1], f_am[2], f_rv[0], f_rv[1], f_rv[2], f_rsc}),
    .ctl_o (r_ctl),
    .m_o   (r_m),
    .tag_o (r_tag)
  );

  // normalize: |a_i| * 2^F / m in three lanes
  logic [NW-1:0]  num [3];
  ctl_t           d_ctl;
  logic [NW:0]    d_q [3];
  logic [TW2-1:0] d_tag;

  assign num[0] = {r_tag[7*W-1:6*W], {F{1'b0}}};
  assign num[1] = {r_tag[6*W-1:5*W], {F{1'b0}}};
  assign num[2] = {r_tag[5*W-1:4*W], {F{1'b0}}};

  vmu_div #(.W(W), .F(F), .TW(TW2)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (r_ctl),
    .m_i   (r_m),
    .num_i (num),
    .tag_i ({r_tag[4*W-1:0], r_m}),
    .ctl_o (d_ctl),
    .q_o   (d_q),
    .tag_o (d_tag)
  );

  // result selection per kind
  logic signed [W-1:0]  d_rv [3];
  logic signed [W-1:0]  d_rsc;
  logic [W:0]           d_m;
  logic signed [NW+1:0] qv [3];
  logic [W:0]           qs [3];
  res_t                 asm;

  assign d_rv[0] = d_tag[5*W:4*W+1];
  assign d_rv[1] = d_tag[4*W:3*W+1];
  assign d_rv[2] = d_tag[3*W:2*W+1];
  assign d_rsc   = d_tag[2*W:W+1];
  assign d_m     = d_tag[W:0];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qv[j] = $signed({1'b0, d_q[j]});
      if (d_ctl.neg[j]) qv[j] = -qv[j];
      qs[j] = sat_q(qv[j]);
    end
    asm = '0;
    case (d_ctl.kind) inside
      K_DOT, K_SQ: begin
        asm.sc  = d_rsc;
        asm.sat = d_ctl.flag;
      end
      K_CROSS, K_REFL: begin
        asm.x   = d_rv[0];
        asm.y   = d_rv[1];
        asm.z   = d_rv[2];
        asm.sat = d_ctl.flag;
      end
      K_MAG: begin
        if (d_m > {1'b0, MAXW}) begin
          asm.sc  = MAXW;
          asm.sat = 1'b1;
        end else begin
          asm.sc  = d_m[W-1:0];
        end
      end
      K_NORM: begin
        // a zero vector passes through as zero with the flag clear
        if (!d_ctl.zero) begin
          asm.x   = qs[0][W-1:0];
          asm.y   = qs[1][W-1:0];
          asm.z   = qs[2][W-1:0];
          asm.sat = qs[0][W] | qs[1][W] | qs[2][W];
        end
      end
      default: asm = '0;
    endcase
  end

  // output register and one-entry skid
  logic mv;
  logic out_v_r;
  res_t out_d_r;
  res_t sk_d_r;

  assign mv = d_ctl.vld && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (out_v_r && !out_ch.ready) begin
      if (mv) sk_v_r <= 1'b1;
    end else begin
      out_v_r <= sk_v_r | mv;
      sk_v_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && !out_ch.ready) begin
      if (mv) sk_d_r <= asm;
    end else begin
      out_d_r <= sk_v_r ? sk_d_r : asm;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.r_x       = out_d_r.x;
  assign out_ch.r_y       = out_d_r.y;
  assign out_ch.r_z       = out_d_r.z;
  assign out_ch.r_scalar  = out_d_r.sc;
  assign out_ch.saturated = out_d_r.sat;

  `VMU_ASSERT_IMP(a_skid_needs_out, clk, rst_n, sk_v_r, out_v_r, "skid full with output empty")
  `VMU_ASSERT_NXT(a_skid_drains, clk, rst_n, sk_v_r && out_ch.ready, !sk_v_r, "skid not drained")
  `VMU_ASSERT_IMP(a_skid_fill, clk, rst_n, $rose(sk_v_r), $past(out_v_r && !out_ch.ready), "skid filled without stall")

endmodule

[hw/rtl/vmu_front.sv]
// front pipeline: products, sums, rounding and clamping, reflect multiply
// depends on vmu_pkg
`timescale 1ns / 1ps

module vmu_front import vmu_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [2:0]          kind_i,
  input  logic signed [W-1:0] a_i [3],
  input  logic signed [W-1:0] b_i [3],
  output ctl_t                ctl_o,
  output logic [2*W-1:0]      s_o,
  output logic [W-1:0]        am_o [3],
  output logic signed [W-1:0] rv_o [3],
  output logic signed [W-1:0] rsc_o
);

  localparam int PW = 2 * W;
  localparam int XW = PW + 2;
  localparam logic signed [XW-1:0] HALF = {{(XW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [XW-1:0] MAXX = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] MINX = ~MAXX;
  localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [XW-1:0] rnd(input logic signed [XW-1:0] v);
    return (v + HALF) >>> F;
  endfunction

  // {flag, value}
  function automatic logic [W:0] sat_x(input logic signed [XW-1:0] v);
    if (v > MAXX) return {1'b1, MAXW};
    if (v < MINX) return {1'b1, MINW};
    return {1'b0, v[W-1:0]};
  endfunction

  // stage a: input register
  logic                va_r;
  kind_t               ka_r;
  logic signed [W-1:0] aa_r [3];
  logic signed [W-1:0] ba_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else if (en) va_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ka_r <= kind_t'(kind_i);
      aa_r <= a_i;
      ba_r <= b_i;
    end
  end

  // stage b: six shared multipliers
  logic signed [W-1:0]  opx [6];
  logic signed [W-1:0]  opy [6];
  logic                 vb_r;
  kind_t                kb_r;
  logic signed [W-1:0]  ab_r [3];
  logic signed [W-1:0]  bb_r [3];
  logic signed [PW-1:0] pb_r [6];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      opx[i] = '0;
      opy[i] = '0;
    end
    case (ka_r) inside
      K_CROSS: begin
        opx[0] = aa_r[1]; opy[0] = ba_r[2];
        opx[1] = aa_r[2]; opy[1] = ba_r[1];
        opx[2] = aa_r[2]; opy[2] = ba_r[0];
        opx[3] = aa_r[0]; opy[3] = ba_r[2];
        opx[4] = aa_r[0]; opy[4] = ba_r[1];
        opx[5] = aa_r[1]; opy[5] = ba_r[0];
      end
      K_SQ, K_MAG, K_NORM: begin
        for (int i = 0; i < 3; i++) begin
          opx[i] = aa_r[i];
          opy[i] = aa_r[i];
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          opx[i] = aa_r[i];
          opy[i] = ba_r[i];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else if (en) vb_r <= va_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kb_r <= ka_r;
      ab_r <= aa_r;
      bb_r <= ba_r;
      for (int i = 0; i < 6; i++) pb_r[i] <= opx[i] * opy[i];
    end
  end

  // stage c: sum of three and cross differences
  logic                 vc_r;
  kind_t                kc_r;
  logic signed [W-1:0]  ac_r [3];
  logic signed [W-1:0]  bc_r [3];
  logic signed [XW-1:0] sum_r;
  logic signed [XW-1:0] cd_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else if (en) vc_r <= vb_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kc_r  <= kb_r;
      ac_r  <= ab_r;
      bc_r  <= bb_r;
      sum_r <= XW'(pb_r[0]) + XW'(pb_r[1]) + XW'(pb_r[2]);
      for (int j = 0; j < 3; j++) cd_r[j] <= XW'(pb_r[2*j]) - XW'(pb_r[2*j+1]);
    end
  end

  // stage d: round and clamp
  logic [W:0]           dsat;
  logic [W:0]           csat [3];
  logic                 fd_nxt;
  logic                 vd_r;
  kind_t                kd_r;
  logic signed [W-1:0]  ad_r [3];
  logic signed [W-1:0]  bd_r [3];
  logic signed [W-1:0]  dd_r;
  logic signed [W-1:0]  cvd_r [3];
  logic                 fd_r;
  logic [PW-1:0]        sd_r;
  logic                 zd_r;

  always_comb begin
    dsat = sat_x(rnd(sum_r));
    for (int j = 0; j < 3; j++) csat[j] = sat_x(rnd(cd_r[j]));
    case (kc_r) inside
      K_DOT, K_SQ, K_REFL: fd_nxt = dsat[W];
      K_CROSS:             fd_nxt = csat[0][W] | csat[1][W] | csat[2][W];
      default:             fd_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= 1'b0;
    else if (en) vd_r <= vc_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kd_r <= kc_r;
      ad_r <= ac_r;
      bd_r <= bc_r;
      dd_r <= dsat[W-1:0];
      for (int j = 0; j < 3; j++) cvd_r[j] <= csat[j][W-1:0];
      fd_r <= fd_nxt;
      sd_r <= sum_r[PW-1:0];
      zd_r <= (sum_r == '0);
    end
  end

  // stage e: reflect products b * d
  logic                 ve_r;
  kind_t                ke_r;
  logic signed [W-1:0]  ae_r [3];
  logic signed [W-1:0]  de_r;
  logic signed [W-1:0]  cve_r [3];
  logic                 fe_r;
  logic [PW-1:0]        se_r;
  logic                 ze_r;
  logic signed [PW-1:0] te_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) ve_r <= 1'b0;
    else if (en) ve_r <= vd_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ke_r  <= kd_r;
      ae_r  <= ad_r;
      de_r  <= dd_r;
      cve_r <= cvd_r;
      fe_r  <= fd_r;
      se_r  <= sd_r;
      ze_r  <= zd_r;
      for (int j = 0; j < 3; j++) te_r[j] <= bd_r[j] * dd_r;
    end
  end

  // stage f: round(2 b d) - a, magnitudes of a
  logic [W:0]          rsat [3];
  logic [W-1:0]        amg [3];
  ctl_t                ctl_nxt;
  ctl_t                ctl_r;
  logic [PW-1:0]       s_r;
  logic [W-1:0]        am_r [3];
  logic signed [W-1:0] rv_r [3];
  logic signed [W-1:0] rsc_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rsat[j] = sat_x(rnd(XW'(te_r[j]) <<< 1) - XW'(ae_r[j]));
      amg[j]  = ae_r[j][W-1] ? (~ae_r[j] + W'(1)) : ae_r[j];
    end
    ctl_nxt.vld  = ve_r;
    ctl_nxt.kind = ke_r;
    ctl_nxt.flag = (ke_r == K_REFL) ? (fe_r | rsat[0][W] | rsat[1][W] | rsat[2][W]) : fe_r;
    ctl_nxt.zero = ze_r;
    ctl_nxt.neg  = {ae_r[2][W-1], ae_r[1][W-1], ae_r[0][W-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ctl_r <= '0;
    else if (en) ctl_r <= ctl_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r   <= se_r;
      am_r  <= amg;
      rsc_r <= de_r;
      for (int j = 0; j < 3; j++) rv_r[j] <= (ke_r == K_REFL) ? rsat[j][W-1:0] : cve_r[j];
    end
  end

  assign ctl_o = ctl_r;
  assign s_o   = s_r;
  assign am_o  = am_r;
  assign rv_o  = rv_r;
  assign rsc_o = rsc_r;

endmodule

[hw/rtl/vmu_sqrt.sv]
// square root pipeline, one root bit per stage, rounded to nearest at the end
// depends on vmu_pkg
`timescale 1ns / 1ps

module vmu_sqrt import vmu_pkg::*; #(
  parameter int W  = 32,
  parameter int TW = 224
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  ctl_t            ctl_i,
  input  logic [2*W-1:0]  s_i,
  input  logic [TW-1:0]   tag_i,
  output ctl_t            ctl_o,
  output logic [W:0]      m_o,
  output logic [TW-1:0]   tag_o
);

  localparam int PW = 2 * W;

  ctl_t          ctl_r  [W];
  logic [PW-1:0] rem_r  [W];
  logic [W-1:0]  root_r [W];
  logic [TW-1:0] tag_r  [W];

  for (genvar k = 0; k < W; k++) begin : g_bit
    localparam int B = W - 1 - k;
    ctl_t          ctl_in;
    logic [PW-1:0] rem_in;
    logic [W-1:0]  root_in;
    logic [TW-1:0] tag_in;
    logic [PW:0]   trial;

    if (k == 0) begin : g_first
      assign ctl_in  = ctl_i;
      assign rem_in  = s_i;
      assign root_in = '0;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign ctl_in  = ctl_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign tag_in  = tag_r[k-1];
    end

    // (r + 2^B)^2 - r^2
    assign trial = ((PW+1)'(root_in) << (B + 1)) + ((PW+1)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) ctl_r[k] <= '0;
      else if (en) ctl_r[k] <= ctl_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k] <= tag_in;
        if ({1'b0, rem_in} >= trial) begin
          rem_r[k]  <= rem_in - trial[PW-1:0];
          root_r[k] <= root_in | (W'(1) << B);
        end else begin
          rem_r[k]  <= rem_in;
          root_r[k] <= root_in;
        end
      end
    end
  end

  ctl_t          ctl_o_r;
  logic [W:0]    m_r;
  logic [TW-1:0] tag_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ctl_o_r <= '0;
    else if (en) ctl_o_r <= ctl_r[W-1];
  end

  // round up when the remainder exceeds the root
  always_ff @(posedge clk) begin
    if (en) begin
      m_r     <= {1'b0, root_r[W-1]} + (W+1)'(rem_r[W-1] > PW'(root_r[W-1]));
      tag_o_r <= tag_r[W-1];
    end
  end

  assign ctl_o = ctl_o_r;
  assign m_o   = m_r;
  assign tag_o = tag_o_r;

endmodule

[hw/rtl/vmu_div.sv]
// three-lane restoring divider pipeline, one quotient bit per stage,
// rounded half up at the end; depends on vmu_pkg
`timescale 1ns / 1ps

module vmu_div import vmu_pkg::*; #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int TW = 161
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  ctl_t              ctl_i,
  input  logic [W:0]        m_i,
  input  logic [W+F-1:0]    num_i [3],
  input  logic [TW-1:0]     tag_i,
  output ctl_t              ctl_o,
  output logic [W+F:0]      q_o [3],
  output logic [TW-1:0]     tag_o
);

  localparam int NW = W + F;

  ctl_t          ctl_r [NW];
  logic [W:0]    m_r   [NW];
  logic [W:0]    rem_r [NW][3];
  logic [NW-1:0] nq_r  [NW][3];
  logic [TW-1:0] tag_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_bit
    ctl_t          ctl_in;
    logic [W:0]    m_in;
    logic [W:0]    rem_in [3];
    logic [NW-1:0] nq_in  [3];
    logic [TW-1:0] tag_in;
    logic [W+1:0]  t      [3];
    logic          ge     [3];

    if (k == 0) begin : g_first
      assign ctl_in = ctl_i;
      assign m_in   = m_i;
      assign rem_in = '{default: '0};
      assign nq_in  = num_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign ctl_in = ctl_r[k-1];
      assign m_in   = m_r[k-1];
      assign rem_in = rem_r[k-1];
      assign nq_in  = nq_r[k-1];
      assign tag_in = tag_r[k-1];
    end

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        t[j]  = {rem_in[j], nq_in[j][NW-1]};
        ge[j] = (t[j] >= {1'b0, m_in});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) ctl_r[k] <= '0;
      else if (en) ctl_r[k] <= ctl_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_r[k]   <= m_in;
        tag_r[k] <= tag_in;
        for (int j = 0; j < 3; j++) begin
          rem_r[k][j] <= ge[j] ? W'(t[j] - {1'b0, m_in}) + (W+1)'(0) : t[j][W:0];
          nq_r[k][j]  <= {nq_in[j][NW-2:0], ge[j]};
        end
      end
    end
  end

  ctl_t          ctl_o_r;
  logic [NW:0]   q_r [3];
  logic [TW-1:0] tag_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ctl_o_r <= '0;
    else if (en) ctl_o_r <= ctl_r[NW-1];
  end

  // half up: twice the remainder against the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      tag_o_r <= tag_r[NW-1];
      for (int j = 0; j < 3; j++) begin
        q_r[j] <= {1'b0, nq_r[NW-1][j]} +
                  (NW+1)'({rem_r[NW-1][j], 1'b0} >= {1'b0, m_r[NW-1]});
      end
    end
  end

  assign ctl_o = ctl_o_r;
  assign q_o   = q_r;
  assign tag_o = tag_o_r;

endmodule

[tb/sv/vector3_math_unit_checker.sv]
// scoreboard for the vector3 math unit: watches both channels, predicts each result
// depends on vmu_pkg and the channel interfaces in vmu_if
`timescale 1ns / 1ps

module vector3_math_unit_checker import vmu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  vmu_in_if     in_mon,
  vmu_out_if    out_mon,
  output int    mismatches,
  output int    pending
);

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [31:0] r_x;
    logic [31:0] r_y;
    logic [31:0] r_z;
    logic [31:0] r_scalar;
    logic        saturated;
  } vec_result_t;

  vec_result_t expected_results[$];

  // clamp to the signed 32-bit range, raising the flag on a clamp
  function automatic logic [31:0] clamp32(input wide_t v, inout logic flag);
    if (v > wide_t'(32'sh7fffffff)) begin
      flag = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -wide_t'(64'sh80000000)) begin
      flag = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // round to nearest, ties towards plus infinity, dropping the fraction bits
  function automatic wide_t round_frac(input wide_t v);
    return (v + (wide_t'(1) <<< 15)) >>> 16;
  endfunction

  function automatic wide_t mul_w(input logic [31:0] p, input logic [31:0] q);
    return wide_t'($signed(p)) * wide_t'($signed(q));
  endfunction

  // integer square root rounded to nearest
  function automatic logic [127:0] root_nearest(input logic [127:0] s);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int bit_i = 34; bit_i >= 0; bit_i--) begin
      c = r | (128'd1 << bit_i);
      if (c * c <= s) r = c;
    end
    if (s - r * r > r) r = r + 1;
    return r;
  endfunction

  function automatic vec_result_t predict_vector_op(input logic [2:0] kind,
      input logic [31:0] ax, input logic [31:0] ay, input logic [31:0] az,
      input logic [31:0] bx, input logic [31:0] by, input logic [31:0] bz);
    vec_result_t  res;
    logic         flag;
    logic [31:0]  av[3];
    logic [31:0]  bv[3];
    logic [31:0]  rv[3];
    wide_t        sq;
    wide_t        t;
    logic [127:0] m;
    logic [127:0] num;
    logic [127:0] q;
    logic [127:0] rem;
    logic [31:0]  d;
    res = '0;
    flag = 1'b0;
    av = '{ax, ay, az};
    bv = '{bx, by, bz};
    rv = '{32'd0, 32'd0, 32'd0};
    sq = mul_w(ax, ax) + mul_w(ay, ay) + mul_w(az, az);
    case (kind)
      K_DOT: res.r_scalar = clamp32(round_frac(mul_w(ax, bx) + mul_w(ay, by)
                                               + mul_w(az, bz)), flag);
      K_CROSS: begin
        rv[0] = clamp32(round_frac(mul_w(ay, bz) - mul_w(az, by)), flag);
        rv[1] = clamp32(round_frac(mul_w(az, bx) - mul_w(ax, bz)), flag);
        rv[2] = clamp32(round_frac(mul_w(ax, by) - mul_w(ay, bx)), flag);
      end
      K_SQ:  res.r_scalar = clamp32(round_frac(sq), flag);
      K_MAG: res.r_scalar = clamp32(wide_t'(root_nearest(sq)), flag);
      K_NORM: begin
        if (sq == 0) begin
          // zero vector passes through with the flag clear
          rv = av;
        end else begin
          m = root_nearest(sq);
          for (int i = 0; i < 3; i++) begin
            num = 128'(($signed(av[i]) < 0) ? -wide_t'($signed(av[i]))
                                            : wide_t'($signed(av[i]))) << 16;
            q = num / m;
            rem = num % m;
            if (rem >= m - rem) q = q + 1;
            rv[i] = clamp32(($signed(av[i]) < 0) ? -wide_t'(q) : wide_t'(q), flag);
          end
        end
      end
      K_REFL: begin
        d = clamp32(round_frac(mul_w(ax, bx) + mul_w(ay, by) + mul_w(az, bz)), flag);
        for (int i = 0; i < 3; i++) begin
          t = mul_w(bv[i], d);
          t = round_frac(t + t);
          rv[i] = clamp32(t - wide_t'($signed(av[i])), flag);
        end
      end
      default: flag = 1'b0;
    endcase
    res.r_x = rv[0];
    res.r_y = rv[1];
    res.r_z = rv[2];
    res.saturated = flag;
    return res;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    vec_result_t want;
    vec_result_t got;
    if (!rst_n) begin
      mismatches <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(predict_vector_op(in_mon.kind, in_mon.a_x,
            in_mon.a_y, in_mon.a_z, in_mon.b_x, in_mon.b_y, in_mon.b_z));
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.r_x, out_mon.r_y, out_mon.r_z, out_mon.r_scalar,
                out_mon.saturated};
        if (expected_results.size() == 0) begin
          if (mismatches < 10) $display("unexpected result transfer %h", got);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_results.pop_front();
          if (want !== got) begin
            if (mismatches < 10)
              $display("mismatch: exp x=%h y=%h z=%h s=%h f=%b got x=%h y=%h z=%h s=%h f=%b",
                       want.r_x, want.r_y, want.r_z, want.r_scalar, want.saturated,
                       got.r_x, got.r_y, got.r_z, got.r_scalar, got.saturated);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

[tb/sv/vector3_math_unit_test.sv]
// top of the vector3 math unit testbench: clock, reset, stimulus, verdict
// depends on vmu_pkg, vmu_if, vector3_math_unit and vector3_math_unit_checker
`timescale 1ns / 1ps

module vector3_math_unit_test import vmu_pkg::*;;

  // the two codes the block leaves unused
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;
  localparam int RANDOM_ITEMS = 1530;
  localparam int CALM_ITEMS   = 200;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 120;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   pending;
  bit   calm;
  int   idle_cycles;
  int   sink_stall;

  vmu_in_if  in_ch();
  vmu_out_if out_ch();

  vector3_math_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  vector3_math_unit_checker scoreboard (
    .clk(clk),
    .rst_n(rst_n),
    .in_mon(in_ch),
    .out_mon(out_ch),
    .mismatches(mismatches),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: random stall bursts, none once the run turns calm
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_stall <= 0;
    end else if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      sink_stall <= $urandom_range(1, 19) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // watchdog: cycles without any transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** vector3_math_unit: FAILED **");
        $finish;
      end
    end
  end

  // field mix: full random, values near one, near zero, extremes, shifted random
  function automatic logic [31:0] pick_component();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return 32'($signed($urandom_range(0, 32'h60000)) - 32'sh30000);
      3: return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
      4: return 32'($signed($urandom_range(0, 32'h2000)) - 32'sh1000);
      default: return 32'($signed($urandom) >>> $urandom_range(0, 24));
    endcase
  endfunction

  // one input transfer; valid stays high into the next item
  task automatic send_item(input logic [2:0] kind, input logic [31:0] ax,
      input logic [31:0] ay, input logic [31:0] az, input logic [31:0] bx,
      input logic [31:0] by, input logic [31:0] bz);
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.a_x <= ax;
    in_ch.a_y <= ay;
    in_ch.a_z <= az;
    in_ch.b_x <= bx;
    in_ch.b_y <= by;
    in_ch.b_z <= bz;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic send_random();
    logic [2:0] k;
    k = ($urandom_range(0, 39) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    send_item(k, pick_component(), pick_component(), pick_component(),
              pick_component(), pick_component(), pick_component());
  endtask

  initial begin
    logic [2:0] k;
    rst_n = 1'b0;
    calm = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = K_DOT;
    in_ch.a_x = '0;
    in_ch.a_y = '0;
    in_ch.a_z = '0;
    in_ch.b_x = '0;
    in_ch.b_y = '0;
    in_ch.b_z = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: each kind at the extremes, zero vector, unit vectors, spare codes
    send_item(K_DOT, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_item(K_DOT, 32'h00010000, 32'h00020000, 32'hffff0000,
              32'h00008000, 32'h00010000, 32'h00010000);
    send_item(K_CROSS, 32'h80000000, 32'h7fffffff, 32'h80000000,
              32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_item(K_CROSS, 32'h00010000, 32'h0, 32'h0, 32'h0, 32'h00010000, 32'h0);
    send_item(K_SQ, 32'h80000000, 32'h80000000, 32'h80000000, 32'h0, 32'h0, 32'h0);
    send_item(K_SQ, 32'h00000001, 32'hffffffff, 32'h00008000, 32'h0, 32'h0, 32'h0);
    send_item(K_MAG, 32'h80000000, 32'h80000000, 32'h80000000, 32'h0, 32'h0, 32'h0);
    send_item(K_MAG, 32'h00030000, 32'h00040000, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(K_MAG, 32'h0, 32'h0, 32'h0, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_item(K_NORM, 32'h0, 32'h0, 32'h0, 32'h12345678, 32'h0, 32'h0);
    send_item(K_NORM, 32'h00000001, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(K_NORM, 32'h80000000, 32'h7fffffff, 32'h00000001, 32'h0, 32'h0, 32'h0);
    send_item(K_NORM, 32'hfffd0000, 32'h00040000, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(K_REFL, 32'h00010000, 32'hffff0000, 32'h0, 32'h0, 32'h00010000, 32'h0);
    send_item(K_REFL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_item(K_REFL, 32'h80000000, 32'h0, 32'h0, 32'h00000001, 32'h0, 32'h0);
    send_item(KIND_SPARE_A, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_item(KIND_SPARE_B, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h80000000);

    // random part, with one pause that lets the pipeline drain completely
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      maybe_gap();
      send_random();
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("** vector3_math_unit: PASSED **");
    end else begin
      $display("** vector3_math_unit: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/vmu_pkg.sv
hw/rtl/vmu_if.sv
hw/rtl/vmu_front.sv
hw/rtl/vmu_sqrt.sv
hw/rtl/vmu_div.sv
hw/rtl/vector3_math_unit.sv
tb/sv/vector3_math_unit_checker.sv
tb/sv/vector3_math_unit_test.sv
